/* sv/dsn_pkg.sv */
// dsn_pkg: shared types and constants for the decimal text parser
// used by dsn_front, dsn_queue, dsn_back and the top level
`default_nettype none

package dsn_pkg;

  localparam int MAX_DIGITS     = 19;
  localparam int EXPONENT_LIMIT = 32767;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;

  typedef enum logic [2:0] {
    CL_SPACE,
    CL_DIGIT,
    CL_PLUS,
    CL_MINUS,
    CL_POINT,
    CL_EXP,
    CL_OTHER
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_INT,
    PH_FRAC,
    PH_ESTART,
    PH_EDIG,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic               negative;
    logic [63:0]        significand;
    logic signed [15:0] decimal_exponent;
    logic               inexact;
    logic               exponent_saturated;
    logic               no_digits;
  } result_t;

endpackage

`default_nettype wire

/* sv/dsn_front.sv */
// dsn_front: sorts each incoming character into a token class
// depends on dsn_pkg
`default_nettype none

module dsn_front (
  input  wire logic [7:0]      character,
  input  wire logic            last,
  output dsn_pkg::token_t      tok
);

  always_comb begin
    tok.last  = last;
    tok.digit = 4'(character - dsn_pkg::CH_ZERO);
    unique case (character) inside
      [dsn_pkg::CH_TAB:dsn_pkg::CH_CR], dsn_pkg::CH_SPACE: tok.cls = dsn_pkg::CL_SPACE;
      [dsn_pkg::CH_ZERO:dsn_pkg::CH_NINE]:                  tok.cls = dsn_pkg::CL_DIGIT;
      dsn_pkg::CH_PLUS:                                     tok.cls = dsn_pkg::CL_PLUS;
      dsn_pkg::CH_MINUS:                                    tok.cls = dsn_pkg::CL_MINUS;
      dsn_pkg::CH_POINT:                                    tok.cls = dsn_pkg::CL_POINT;
      dsn_pkg::CH_UPPER_E, dsn_pkg::CH_LOWER_E:             tok.cls = dsn_pkg::CL_EXP;
      default:                                              tok.cls = dsn_pkg::CL_OTHER;
    endcase
  end

endmodule

`default_nettype wire

/* sv/dsn_queue.sv */
// dsn_queue: small token queue between the classifier and the parser
// depends on dsn_pkg
`default_nettype none

module dsn_queue #(
  parameter int DEPTH = dsn_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire dsn_pkg::token_t wr_tok,
  output logic                 full,
  input  wire logic            rd_en,
  output dsn_pkg::token_t      rd_tok,
  output logic                 rd_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dsn_pkg::token_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok   = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/dsn_back.sv */
// dsn_back: parser state machine, digit and exponent accumulators, result register
// depends on dsn_pkg
`default_nettype none

module dsn_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dsn_pkg::token_t tok,
  input  wire logic            tok_valid,
  output logic                 tok_take,
  input  wire logic            pop,
  output dsn_pkg::result_t     result,
  output logic                 result_valid
);

  localparam logic signed [15:0] SCALE_MAX = 16'(dsn_pkg::EXPONENT_LIMIT);
  localparam logic signed [15:0] SCALE_MIN = -SCALE_MAX;
  localparam logic [19:0]        EXP_MAX   = 20'(2 * dsn_pkg::EXPONENT_LIMIT);
  localparam logic signed [17:0] NET_MAX   = 18'(dsn_pkg::EXPONENT_LIMIT);
  localparam logic signed [17:0] NET_MIN   = -NET_MAX;

  dsn_pkg::phase_t    phase, phase_next, eff;
  logic               sign_neg, sign_neg_next;
  logic [63:0]        acc, acc_next, acc_x10;
  logic [4:0]         kept, kept_next;
  logic signed [15:0] scale, scale_next;
  logic [15:0]        exp_acc, exp_acc_next;
  logic [19:0]        exp_x10;
  logic               exp_neg, exp_neg_next;
  logic               dropped, dropped_next;
  logic               sat, sat_next;
  logic               any_digit, any_digit_next;
  logic signed [17:0] net;
  dsn_pkg::result_t   res;

  assign tok_take = tok_valid && (!tok.last || !result_valid || pop);
  assign acc_x10  = (acc << 3) + (acc << 1) + 64'(tok.digit);
  assign exp_x10  = (20'(exp_acc) << 3) + (20'(exp_acc) << 1) + 20'(tok.digit);
  assign eff      = (phase == dsn_pkg::PH_SKIP) ? dsn_pkg::PH_INT : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= dsn_pkg::PH_SKIP;
      sign_neg  <= 1'b0;
      acc       <= '0;
      kept      <= '0;
      scale     <= '0;
      exp_acc   <= '0;
      exp_neg   <= 1'b0;
      dropped   <= 1'b0;
      sat       <= 1'b0;
      any_digit <= 1'b0;
    end else if (tok_take) begin
      phase     <= phase_next;
      sign_neg  <= sign_neg_next;
      acc       <= acc_next;
      kept      <= kept_next;
      scale     <= scale_next;
      exp_acc   <= exp_acc_next;
      exp_neg   <= exp_neg_next;
      dropped   <= dropped_next;
      sat       <= sat_next;
      any_digit <= any_digit_next;
    end
  end

  always_comb begin
    phase_next     = phase;
    sign_neg_next  = sign_neg;
    acc_next       = acc;
    kept_next      = kept;
    scale_next     = scale;
    exp_acc_next   = exp_acc;
    exp_neg_next   = exp_neg;
    dropped_next   = dropped;
    sat_next       = sat;
    any_digit_next = any_digit;

    if (phase == dsn_pkg::PH_SKIP && tok.cls == dsn_pkg::CL_SPACE) begin
      phase_next = dsn_pkg::PH_SKIP;
    end else if (phase == dsn_pkg::PH_SKIP &&
                 (tok.cls == dsn_pkg::CL_PLUS || tok.cls == dsn_pkg::CL_MINUS)) begin
      phase_next    = dsn_pkg::PH_INT;
      sign_neg_next = (tok.cls == dsn_pkg::CL_MINUS);
    end else begin
      phase_next = eff;
      unique case (eff)
        dsn_pkg::PH_INT, dsn_pkg::PH_FRAC: begin
          if (tok.cls == dsn_pkg::CL_DIGIT) begin
            any_digit_next = 1'b1;
            if (kept < 5'(dsn_pkg::MAX_DIGITS)) begin
              acc_next = acc_x10;
              if (acc_x10 != '0) begin
                kept_next = kept + 1'b1;
              end
              if (eff == dsn_pkg::PH_FRAC) begin
                if (scale > SCALE_MIN) begin
                  scale_next = scale - 16'sd1;
                end else begin
                  sat_next = 1'b1;
                end
              end
            end else begin
              dropped_next = 1'b1;
              if (eff == dsn_pkg::PH_INT) begin
                if (scale < SCALE_MAX) begin
                  scale_next = scale + 16'sd1;
                end else begin
                  sat_next = 1'b1;
                end
              end
            end
          end else if (tok.cls == dsn_pkg::CL_POINT && eff == dsn_pkg::PH_INT) begin
            phase_next = dsn_pkg::PH_FRAC;
          end else if (tok.cls == dsn_pkg::CL_EXP) begin
            phase_next = dsn_pkg::PH_ESTART;
          end else begin
            phase_next = dsn_pkg::PH_DONE;
          end
        end
        dsn_pkg::PH_ESTART, dsn_pkg::PH_EDIG: begin
          if (tok.cls == dsn_pkg::CL_DIGIT) begin
            phase_next = dsn_pkg::PH_EDIG;
            if (exp_x10 > EXP_MAX) begin
              exp_acc_next = 16'(EXP_MAX);
              sat_next     = 1'b1;
            end else begin
              exp_acc_next = 16'(exp_x10);
            end
          end else if (eff == dsn_pkg::PH_ESTART &&
                       (tok.cls == dsn_pkg::CL_PLUS || tok.cls == dsn_pkg::CL_MINUS)) begin
            phase_next   = dsn_pkg::PH_EDIG;
            exp_neg_next = (tok.cls == dsn_pkg::CL_MINUS);
          end else begin
            phase_next = dsn_pkg::PH_DONE;
          end
        end
        default: begin
          phase_next = eff;
        end
      endcase
    end

    // net exponent with clamp
    if (exp_neg_next) begin
      net = 18'(scale_next) - $signed({2'b00, exp_acc_next});
    end else begin
      net = 18'(scale_next) + $signed({2'b00, exp_acc_next});
    end

    res.negative           = sign_neg_next;
    res.significand        = acc_next;
    res.inexact            = dropped_next;
    res.exponent_saturated = sat_next;
    res.no_digits          = 1'b0;
    if (net > NET_MAX) begin
      res.decimal_exponent   = SCALE_MAX;
      res.exponent_saturated = 1'b1;
    end else if (net < NET_MIN) begin
      res.decimal_exponent   = SCALE_MIN;
      res.exponent_saturated = 1'b1;
    end else begin
      res.decimal_exponent = 16'(net);
    end
    if (!any_digit_next) begin
      res.significand        = '0;
      res.decimal_exponent   = '0;
      res.inexact            = 1'b0;
      res.exponent_saturated = 1'b0;
      res.no_digits          = 1'b1;
    end

    if (tok.last) begin
      phase_next     = dsn_pkg::PH_SKIP;
      sign_neg_next  = 1'b0;
      acc_next       = '0;
      kept_next      = '0;
      scale_next     = '0;
      exp_acc_next   = '0;
      exp_neg_next   = 1'b0;
      dropped_next   = 1'b0;
      sat_next       = 1'b0;
      any_digit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_take && tok.last) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (tok_take && tok.last) begin
      result_valid <= 1'b1;
    end else if (pop) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* sv/decimal_scientific_text_to_number.sv */
// Parses decimal scientific-notation text, one character per word, into sign,
// integer significand (up to 19 kept digits) and a saturated decimal exponent.
// Leading whitespace is skipped; the first character that does not fit ends the
// number and the rest is ignored until the word flagged last, which yields one
// result word. One character word is taken every clock cycle while full is low:
// the parser does its multiply-by-ten and add combinationally, and a small token
// queue sits between the classifier and the parser. A result passes through the
// queue and then the result register and is held there, so input keeps flowing
// while it waits to be popped until the next last character reaches the parser;
// then the queue fills and full rises.
// depends on dsn_pkg, dsn_front, dsn_queue, dsn_back
`default_nettype none

module decimal_scientific_text_to_number #(
  parameter int QUEUE_DEPTH = dsn_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [7:0]         character,
  input  wire logic               last,
  input  wire logic               push,
  output logic                    full,
  output logic                    negative,
  output logic [63:0]             significand,
  output logic signed [15:0]      decimal_exponent,
  output logic                    inexact,
  output logic                    exponent_saturated,
  output logic                    no_digits,
  output logic                    empty,
  input  wire logic               pop
);

  dsn_pkg::token_t  in_tok;
  dsn_pkg::token_t  q_tok;
  logic             q_valid;
  logic             q_take;
  dsn_pkg::result_t result;
  logic             result_valid;

  dsn_front u_front (
    .character (character),
    .last      (last),
    .tok       (in_tok)
  );

  dsn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_tok   (in_tok),
    .full     (full),
    .rd_en    (q_take),
    .rd_tok   (q_tok),
    .rd_valid (q_valid)
  );

  dsn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok          (q_tok),
    .tok_valid    (q_valid),
    .tok_take     (q_take),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid)
  );

  assign empty              = !result_valid;
  assign negative           = result.negative;
  assign significand        = result.significand;
  assign decimal_exponent   = result.decimal_exponent;
  assign inexact            = result.inexact;
  assign exponent_saturated = result.exponent_saturated;
  assign no_digits          = result.no_digits;

`ifndef SYNTHESIS
  a_no_digits_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && no_digits) |-> (significand == '0 && decimal_exponent == '0))
    else $error("no_digits result carries a nonzero value");

  a_exp_in_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (decimal_exponent <= 16'sd32767 && decimal_exponent >= -16'sd32767))
    else $error("decimal exponent outside limit");

  a_inexact_needs_digits: assert property (@(posedge clk) disable iff (rst)
    (!empty && no_digits) |-> (!inexact && !exponent_saturated))
    else $error("flags set on a result with no digits");
`endif

endmodule

`default_nettype wire
